>>> rtl/core/ysl_pkg.sv
package ysl_pkg;

  // Field and register widths.
  localparam int YAW_W      = 16;
  localparam int MAX_RATE_W = 15;
  localparam int MAX_STEP_W = 15;
  localparam int HZ_W       = 10;
  localparam int CFG_W      = 15;
  localparam int CFG_IDX_W  = 2;

  // Working width for heading differences, including one wrap of 2*pi.
  localparam int CALC_W = 19;
  // Width of the in-reach rate product (difference times items per second).
  localparam int PROD_W = 28;

  // Q3.13 angle constants.
  localparam logic signed [CALC_W-1:0] PI_Q13     = 19'sd25736;
  localparam logic signed [CALC_W-1:0] TWO_PI_Q13 = 19'sd51472;

  // Saturation limits of the raw rate.
  localparam logic signed [PROD_W-1:0] RATE_HI = 28'sd32767;
  localparam logic signed [PROD_W-1:0] RATE_LO = -28'sd32768;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE_HZ = 2'd2;

  // Reset values of the registers.
  localparam logic [MAX_RATE_W-1:0] MAX_RATE_RST     = 15'd12868;
  localparam logic [MAX_STEP_W-1:0] MAX_STEP_RST     = 15'd257;
  localparam logic [HZ_W-1:0]       STEP_RATE_HZ_RST = 10'd50;

  typedef logic signed [YAW_W-1:0] yaw_t;

  typedef struct packed {
    logic [MAX_RATE_W-1:0] max_rate;
    logic [MAX_STEP_W-1:0] max_step;
    logic [HZ_W-1:0]       step_rate_hz;
  } cfg_t;

  typedef struct packed {
    yaw_t cmd;
    yaw_t rate;
  } step_res_t;

  // Brings a heading back into range by at most one turn.
  function automatic logic signed [CALC_W-1:0] wrap_once(input logic signed [CALC_W-1:0] y);
    logic signed [CALC_W-1:0] r;
    r = y;
    if (y > PI_Q13) begin
      r = y - TWO_PI_Q13;
    end else if (y < -PI_Q13) begin
      r = y + TWO_PI_Q13;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ysl_in_if.sv
interface ysl_in_if;
  logic          valid;
  logic          ready;
  ysl_pkg::yaw_t present_yaw;
  ysl_pkg::yaw_t target_yaw;

  modport source (output valid, output present_yaw, output target_yaw, input ready);
  modport sink   (input valid, input present_yaw, input target_yaw, output ready);
endinterface

>>> rtl/core/ysl_out_if.sv
interface ysl_out_if;
  logic          valid;
  logic          ready;
  ysl_pkg::yaw_t yaw_cmd;
  ysl_pkg::yaw_t yaw_rate_cmd;

  modport source (output valid, output yaw_cmd, output yaw_rate_cmd, input ready);
  modport sink   (input valid, input yaw_cmd, input yaw_rate_cmd, output ready);
endinterface

>>> rtl/core/yaw_slew_limiter_unit.sv
// Heading slew limiter with wrap-around. Each input word carries a present and a
// desired heading in signed Q3.13 radians; the block steps towards the desired
// heading along the shorter way round the circle, limits the step to max_step and
// wraps a result that leaves plus or minus pi. Each output word carries that
// command together with a smoothed yaw rate: the raw rate (plus or minus max_rate
// for a limited step or a reach across the wrap, otherwise the difference times
// step_rate_hz saturated to 16 bits) averaged with the previous smoothed rate.
// The block takes one word per clock cycle and delivers one word per cycle while
// the output is not stalled by out_ch.ready; a word accepted at an edge enters
// the input register, then passes the step register and the output register,
// where it is presented. The smoothing recurrence closes within the last of
// these stages, so it does not hold back the flow of words.
// Registers must only be written while no words are in flight.
module yaw_slew_limiter_unit (
  input  logic                           clk,
  input  logic                           rst,
  ysl_in_if.sink                         in_ch,
  ysl_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ysl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ysl_pkg::CFG_W-1:0]      cfg_data
);
  import ysl_pkg::*;

  // Configuration registers.
  cfg_t cfg;

  // Input register stage.
  logic s1_valid;
  yaw_t s1_cur;
  yaw_t s1_tgt;
  logic s1_ready;

  // Step register stage: command and raw rate.
  logic      s2_valid;
  step_res_t s2_res;
  logic      s2_ready;
  step_res_t step_res;

  // Output register stage and smoothing state.
  logic o_valid;
  yaw_t o_cmd;
  yaw_t o_rate;
  logic o_ready;
  yaw_t smoothed_rate;
  yaw_t avg;

  // Each stage takes a new word when it is empty or its word moves on.
  assign o_ready  = !o_valid || out_ch.ready;
  assign s2_ready = !s2_valid || o_ready;
  assign s1_ready = !s1_valid || s2_ready;

  assign in_ch.ready         = s1_ready;
  assign out_ch.valid        = o_valid;
  assign out_ch.yaw_cmd      = o_cmd;
  assign out_ch.yaw_rate_cmd = o_rate;

  ysl_step u_step (
    .cfg         (cfg),
    .present_yaw (s1_cur),
    .target_yaw  (s1_tgt),
    .res         (step_res)
  );

  ysl_avg u_avg (
    .smoothed (smoothed_rate),
    .raw      (s2_res.rate),
    .avg      (avg)
  );

  // Control state, configuration and the smoothed rate.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_rate     <= MAX_RATE_RST;
      cfg.max_step     <= MAX_STEP_RST;
      cfg.step_rate_hz <= STEP_RATE_HZ_RST;
      s1_valid         <= 1'b0;
      s2_valid         <= 1'b0;
      o_valid          <= 1'b0;
      smoothed_rate    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_RATE:     cfg.max_rate     <= cfg_data[MAX_RATE_W-1:0];
          REG_MAX_STEP:     cfg.max_step     <= cfg_data[MAX_STEP_W-1:0];
          REG_STEP_RATE_HZ: cfg.step_rate_hz <= cfg_data[HZ_W-1:0];
          default: begin
            // Writes beyond the register list are ignored.
          end
        endcase
      end
      if (s1_ready) begin
        s1_valid <= in_ch.valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (o_ready) begin
        o_valid <= s2_valid;
      end
      // The smoothed rate advances exactly once per word, as it enters the output.
      if (o_ready && s2_valid) begin
        smoothed_rate <= avg;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_cur <= in_ch.present_yaw;
      s1_tgt <= in_ch.target_yaw;
    end
    if (s2_ready && s1_valid) begin
      s2_res <= step_res;
    end
    if (o_ready && s2_valid) begin
      o_cmd  <= s2_res.cmd;
      o_rate <= avg;
    end
  end

endmodule

>>> rtl/core/ysl_step.sv
module ysl_step (
  input  ysl_pkg::cfg_t      cfg,
  input  ysl_pkg::yaw_t      present_yaw,
  input  ysl_pkg::yaw_t      target_yaw,
  output ysl_pkg::step_res_t res
);
  import ysl_pkg::*;

  logic signed [CALC_W-1:0] cur;
  logic signed [CALC_W-1:0] tgt;
  logic signed [CALC_W-1:0] d;
  logic signed [CALC_W-1:0] step;
  logic signed [CALC_W-1:0] mrate;
  logic signed [CALC_W-1:0] neg_mrate;
  logic signed [CALC_W-1:0] down;
  logic signed [CALC_W-1:0] up;
  logic signed [CALC_W-1:0] cmd;
  logic signed [PROD_W-1:0] prod;
  yaw_t                     sat;
  yaw_t                     rate;

  assign cur       = {{(CALC_W-YAW_W){present_yaw[YAW_W-1]}}, present_yaw};
  assign tgt       = {{(CALC_W-YAW_W){target_yaw[YAW_W-1]}}, target_yaw};
  assign step      = {{(CALC_W-MAX_STEP_W){1'b0}}, cfg.max_step};
  assign mrate     = {{(CALC_W-MAX_RATE_W){1'b0}}, cfg.max_rate};
  assign neg_mrate = -mrate;
  assign d         = tgt - cur;
  assign down      = wrap_once(cur - step);
  assign up        = wrap_once(cur + step);

  // Rate when the target is within reach: difference times items per second.
  assign prod = $signed({{(PROD_W-CALC_W){d[CALC_W-1]}}, d})
              * $signed({{(PROD_W-HZ_W){1'b0}}, cfg.step_rate_hz});

  always_comb begin
    if (prod > RATE_HI) begin
      sat = yaw_t'(RATE_HI[YAW_W-1:0]);
    end else if (prod < RATE_LO) begin
      sat = yaw_t'(RATE_LO[YAW_W-1:0]);
    end else begin
      sat = prod[YAW_W-1:0];
    end
  end

  always_comb begin
    priority if (d > PI_Q13) begin
      // The short way round is downward, across minus pi.
      cmd  = ((d - TWO_PI_Q13) < -step) ? down : tgt;
      rate = neg_mrate[YAW_W-1:0];
    end else if (d < -PI_Q13) begin
      cmd  = ((d + TWO_PI_Q13) > step) ? up : tgt;
      rate = mrate[YAW_W-1:0];
    end else if (d < -step) begin
      cmd  = down;
      rate = neg_mrate[YAW_W-1:0];
    end else if (d > step) begin
      cmd  = up;
      rate = mrate[YAW_W-1:0];
    end else begin
      cmd  = tgt;
      rate = sat;
    end
  end

  assign res.cmd  = cmd[YAW_W-1:0];
  assign res.rate = rate;

endmodule

>>> rtl/core/ysl_avg.sv
module ysl_avg (
  input  ysl_pkg::yaw_t smoothed,
  input  ysl_pkg::yaw_t raw,
  output ysl_pkg::yaw_t avg
);
  import ysl_pkg::*;

  logic [YAW_W:0] sum;

  // Dropping the low bit of the extended sum rounds towards minus infinity.
  assign sum = {smoothed[YAW_W-1], smoothed} + {raw[YAW_W-1], raw};
  assign avg = sum[YAW_W:1];

endmodule

>>> rtl/core/ysl_checker.sv
module ysl_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input ysl_pkg::yaw_t yaw_cmd,
  input ysl_pkg::yaw_t yaw_rate_cmd
);
  import ysl_pkg::*;

  // Words accepted but not yet delivered.
  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 2'd1;
    end
  end

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(yaw_cmd) && $stable(yaw_rate_cmd))
    else $error("output word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid just after reset");

  // No output word without an accepted input word behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("output word with no input word outstanding");

  // The three stages hold at most three words; a fourth is never taken.
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd3 && !out_acc |-> !in_acc)
    else $error("input word accepted with the pipeline full");

endmodule

bind yaw_slew_limiter_unit ysl_checker u_ysl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .yaw_cmd      (out_ch.yaw_cmd),
  .yaw_rate_cmd (out_ch.yaw_rate_cmd)
);

>>> sim/yaw_slew_limiter_unit_tb.sv
module yaw_slew_limiter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ysl_pkg::*;

  // Half and full turn in Q3.13 radians, kept as plain integers for the
  // predictor's arithmetic.
  localparam int HALF_TURN = 25736;
  localparam int FULL_TURN = 51472;

  // Cycles of silence on both channels that end the run as hung.
  localparam int QUIET_LIMIT = 1000;
  // The block passes a word through its input, step and output registers; the
  // pipeline is then left to settle before a register write so that nothing is
  // left in flight.
  localparam int PIPE_DRAIN = 8;

  // The port has room for a fourth register index that the block ignores.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Kinds of random heading pair, chosen so that every branch of the
  // limiter sees plenty of traffic.
  typedef enum logic [2:0] {
    SHAPE_SPREAD,
    SHAPE_NEAR,
    SHAPE_SEAM,
    SHAPE_CORNER,
    SHAPE_TRACK
  } heading_shape_e;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ysl_in_if  heading_in ();
  ysl_out_if command_out ();

  yaw_slew_limiter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (heading_in),
    .out_ch    (command_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the limiter's registers and of its smoothed rate.
  int lim_max_rate;
  int lim_max_step;
  int lim_step_hz;
  int smoothed_q;

  // Predicted output words, oldest first.
  step_res_t pending_q[$];
  step_res_t oldest_word;

  int   fail_count = 0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   quiet_cycles = 0;
  yaw_t last_cmd = '0;
  yaw_t track_goal = '0;

  // Free-running clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A result past plus or minus pi is brought back by exactly one turn.
  function automatic int fold_turn(input int y);
    if (y > HALF_TURN) begin
      return y - FULL_TURN;
    end else if (y < -HALF_TURN) begin
      return y + FULL_TURN;
    end
    return y;
  endfunction

  function automatic int clamp_heading(input int v);
    if (v > HALF_TURN) begin
      return HALF_TURN;
    end else if (v < -HALF_TURN) begin
      return -HALF_TURN;
    end
    return v;
  endfunction

  function automatic int rand_heading();
    return int'($urandom_range(0, FULL_TURN)) - HALF_TURN;
  endfunction

  // Works out the word that the limiter gives for one heading pair and moves
  // the smoothed rate on. The difference is taken at full precision; the
  // shorter way round is chosen first, then the step is limited, and the raw
  // rate is averaged with the stored rate, rounding towards minus infinity.
  function automatic step_res_t slew_step(input yaw_t cur, input yaw_t tgt);
    int        c;
    int        t;
    int        d;
    int        cmd;
    int        raw;
    step_res_t res;
    c = cur;
    t = tgt;
    d = t - c;
    if (d > HALF_TURN) begin
      // The short way runs downwards across the seam.
      cmd = (d - FULL_TURN < -lim_max_step) ? fold_turn(c - lim_max_step) : t;
      raw = -lim_max_rate;
    end else if (d < -HALF_TURN) begin
      cmd = (d + FULL_TURN > lim_max_step) ? fold_turn(c + lim_max_step) : t;
      raw = lim_max_rate;
    end else if (d < -lim_max_step) begin
      cmd = fold_turn(c - lim_max_step);
      raw = -lim_max_rate;
    end else if (d > lim_max_step) begin
      cmd = fold_turn(c + lim_max_step);
      raw = lim_max_rate;
    end else begin
      // Within reach: the rate follows the difference, saturated to 16 bits.
      cmd = t;
      raw = d * lim_step_hz;
      if (raw > 32767) begin
        raw = 32767;
      end else if (raw < -32768) begin
        raw = -32768;
      end
    end
    smoothed_q = (smoothed_q + raw) >>> 1;
    res.cmd  = yaw_t'(cmd);
    res.rate = yaw_t'(smoothed_q);
    return res;
  endfunction

  // Writes one register and mirrors the write in our copy. Indexes past the
  // three registers leave everything as it was.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_W'(value);
    case (idx)
      REG_MAX_RATE: begin
        lim_max_rate = value & 32'h7FFF;
      end
      REG_MAX_STEP: begin
        lim_max_step = value & 32'h7FFF;
      end
      REG_STEP_RATE_HZ: begin
        lim_step_hz = value & 32'h3FF;
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_limits(input int max_rate, input int max_step, input int hz);
    write_reg(REG_MAX_RATE, max_rate);
    write_reg(REG_MAX_STEP, max_step);
    write_reg(REG_STEP_RATE_HZ, hz);
  endtask

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  // Holds the sender back until every predicted word has come out, then lets
  // the pipeline settle. Registers are only ever written after this.
  task automatic drain_pipeline();
    @(negedge clk);
    heading_in.valid = 1'b0;
    while (pending_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // Offers one heading pair, with random gaps in front of it, and records the
  // predicted word once the block has taken it. Valid is left high so that
  // back-to-back words need no dip; a gap in the next call or a drain lowers it.
  task automatic push_heading(input yaw_t cur, input yaw_t tgt);
    step_res_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk);
      heading_in.valid       = 1'b0;
      heading_in.present_yaw = yaw_t'($urandom);
      heading_in.target_yaw  = yaw_t'($urandom);
    end
    @(negedge clk);
    heading_in.valid       = 1'b1;
    heading_in.present_yaw = cur;
    heading_in.target_yaw  = tgt;
    @(posedge clk);
    while (heading_in.ready !== 1'b1) begin
      @(posedge clk);
    end
    predicted = slew_step(cur, tgt);
    pending_q.push_back(predicted);
    last_cmd = predicted.cmd;
  endtask

  // Draws one heading pair. Most pairs are well formed: differences around the
  // step limit, pairs across the seam at plus or minus pi, pairs of 0 and plus
  // or minus pi, and runs in which the present heading follows the last command
  // to a held goal, as a real control loop would. The rest span the whole range.
  task automatic random_heading(output yaw_t cur, output yaw_t tgt);
    int             pick;
    int             span;
    int             c;
    int             t;
    heading_shape_e shape;
    pick = $urandom_range(0, 9);
    span = lim_max_step + 2;
    if (span > HALF_TURN) begin
      span = HALF_TURN;
    end
    if (pick < 3) begin
      shape = SHAPE_SPREAD;
    end else if (pick < 5) begin
      shape = SHAPE_NEAR;
    end else if (pick < 7) begin
      shape = SHAPE_SEAM;
    end else if (pick < 8) begin
      shape = SHAPE_CORNER;
    end else begin
      shape = SHAPE_TRACK;
    end
    case (shape)
      SHAPE_NEAR: begin
        c = rand_heading();
        t = clamp_heading(c + int'($urandom_range(0, 2 * span)) - span);
      end
      SHAPE_SEAM: begin
        c = HALF_TURN - int'($urandom_range(0, span));
        t = -HALF_TURN + int'($urandom_range(0, span));
        if ($urandom_range(0, 1) == 1) begin
          c = -c;
          t = -t;
        end
      end
      SHAPE_CORNER: begin
        c = (int'($urandom_range(0, 2)) - 1) * HALF_TURN;
        t = (int'($urandom_range(0, 2)) - 1) * HALF_TURN;
      end
      SHAPE_TRACK: begin
        if ($urandom_range(0, 15) == 0) begin
          track_goal = yaw_t'(rand_heading());
        end
        c = clamp_heading(last_cmd);
        t = track_goal;
      end
      default: begin
        c = rand_heading();
        t = rand_heading();
      end
    endcase
    cur = yaw_t'(c);
    tgt = yaw_t'(t);
  endtask

  // Reset values of the registers: in reach, exactly at the step limit, just
  // past it either way, and a difference of exactly plus or minus pi.
  task automatic test_reset_limits();
    push_heading(16'sd0, 16'sd0);
    push_heading(16'sd0, 16'sd100);
    push_heading(16'sd0, 16'sd257);
    push_heading(16'sd0, 16'sd258);
    push_heading(16'sd0, -16'sd258);
    push_heading(16'sd0, 16'sd25736);
    push_heading(16'sd0, -16'sd25736);
  endtask

  // The short way across the seam, both reached and limited, in both senses.
  // The limited ones leave the range and must wrap by one turn.
  task automatic test_seam_crossing();
    push_heading(16'sd25736, -16'sd25736);
    push_heading(16'sd25600, -16'sd25600);
    push_heading(-16'sd25600, 16'sd25600);
    push_heading(-16'sd25736, 16'sd25736);
  endtask

  // Registers at their extremes: no step and no rate at all, then a step of half a
  // turn, the largest rate and an item rate of 1000 so that the in-reach rate
  // saturates both ways, then a zero item rate and a write to the unused index.
  task automatic test_register_extremes();
    drain_pipeline();
    set_limits(0, 0, 1);
    push_heading(16'sd5, 16'sd5);
    push_heading(16'sd5, 16'sd6);
    push_heading(-16'sd3, -16'sd9);
    drain_pipeline();
    set_limits(32767, HALF_TURN, 1000);
    push_heading(-16'sd25736, 16'sd25736);
    push_heading(16'sd0, 16'sd25736);
    push_heading(16'sd0, -16'sd25736);
    push_heading(16'sd25736, 16'sd0);
    drain_pipeline();
    write_reg(REG_SPARE, 77);
    write_reg(REG_STEP_RATE_HZ, 0);
    push_heading(16'sd100, -16'sd100);
  endtask

  // Headings at the very ends of the 16-bit word, beyond plus or minus pi, then one
  // pair within range, with the step register at its full width.
  task automatic test_beyond_half_turn();
    drain_pipeline();
    write_reg(REG_MAX_STEP, 32767);
    push_heading(-16'sd32768, 16'sd32767);
    push_heading(16'sd32767, -16'sd32768);
    push_heading(16'sd20000, -16'sd20000);
  endtask

  // Six phases of random words: the first pair with a slow receiver, the next
  // pair with a slow sender, the last pair with neither idling. Each phase has
  // its own register setting and, somewhere in the middle, a pause in which
  // the sender waits for every outstanding word to come out.
  task automatic test_random_sweep();
    int   ph;
    int   n;
    int   hold;
    yaw_t cur;
    yaw_t tgt;
    for (ph = 0; ph < 6; ph++) begin
      drain_pipeline();
      case (ph / 2)
        0: set_idling(24, 81);
        1: set_idling(81, 24);
        default: set_idling(0, 0);
      endcase
      case (ph)
        0: set_limits(MAX_RATE_RST, MAX_STEP_RST, STEP_RATE_HZ_RST);
        1: set_limits(32767, HALF_TURN, 1000);
        2: set_limits(0, 0, 1);
        3: set_limits($urandom_range(0, 32767), $urandom_range(0, 600),
                      $urandom_range(1, 1000));
        4: set_limits($urandom_range(0, 32767), $urandom_range(2000, HALF_TURN),
                      $urandom_range(1, 1000));
        default: set_limits($urandom_range(0, 32767), $urandom_range(0, HALF_TURN),
                            $urandom_range(1, 1000));
      endcase
      hold = $urandom_range(50, 250);
      for (n = 0; n < 305; n++) begin
        if (n == hold) begin
          drain_pipeline();
        end
        random_heading(cur, tgt);
        push_heading(cur, tgt);
      end
    end
  endtask

  // Receiver: ready is chosen afresh at every falling edge, and each word
  // taken at a rising edge is compared with the oldest prediction.
  initial begin
    command_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      command_out.ready = ($urandom_range(0, 99) >= snk_idle_pct);
      @(posedge clk);
      if (rst === 1'b0 && command_out.valid === 1'b1 && command_out.ready === 1'b1) begin
        if (pending_q.size() == 0) begin
          fail_count++;
          $display("%0t: word with nothing predicted, yaw_cmd %0d yaw_rate_cmd %0d",
                   $realtime, command_out.yaw_cmd, command_out.yaw_rate_cmd);
        end else begin
          oldest_word = pending_q.pop_front();
          if (command_out.yaw_cmd !== oldest_word.cmd) begin
            fail_count++;
            $display("%0t: yaw_cmd expected %0d actual %0d",
                     $realtime, oldest_word.cmd, command_out.yaw_cmd);
          end
          if (command_out.yaw_rate_cmd !== oldest_word.rate) begin
            fail_count++;
            $display("%0t: yaw_rate_cmd expected %0d actual %0d",
                     $realtime, oldest_word.rate, command_out.yaw_rate_cmd);
          end
        end
      end
    end
  end

  // Watchdog: a long run of cycles in which neither channel moves a word
  // means the block has hung.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((heading_in.valid === 1'b1 && heading_in.ready === 1'b1) ||
          (command_out.valid === 1'b1 && command_out.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // Sequence of tests. Every input is given a known value at time zero and
  // reset is asserted from time zero, once only.
  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = REG_MAX_RATE;
    cfg_data               = '0;
    heading_in.valid       = 1'b0;
    heading_in.present_yaw = '0;
    heading_in.target_yaw  = '0;
    lim_max_rate           = MAX_RATE_RST;
    lim_max_step           = MAX_STEP_RST;
    lim_step_hz            = STEP_RATE_HZ_RST;
    smoothed_q             = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    set_idling(24, 81);
    test_reset_limits();
    test_seam_crossing();
    test_register_extremes();
    test_beyond_half_turn();
    test_random_sweep();

    drain_pipeline();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ysl_pkg.sv
rtl/core/ysl_in_if.sv
rtl/core/ysl_out_if.sv
rtl/core/ysl_step.sv
rtl/core/ysl_avg.sv
rtl/core/yaw_slew_limiter_unit.sv
rtl/core/ysl_checker.sv
sim/yaw_slew_limiter_unit_tb.sv
